/* src/crgb_pkg.sv */
`default_nettype none

package crgb_pkg;

  // Framebuffer size defaults, in words.
  localparam int FB_WIDTH_DEF  = 1024;
  localparam int FB_HEIGHT_DEF = 1024;

  // Field and register widths.
  localparam int POS_W   = 12;  // signed screen placement
  localparam int SIZE_W  = 11;  // image sizes, offsets, counters
  localparam int SCR_W   = 12;  // screen coordinate, up to 2047
  localparam int DELTA_W = 13;  // screen minus source coordinate
  localparam int CLIP_W  = 15;  // signed headroom for clip arithmetic
  localparam int ADDR_W  = 20;
  localparam int PROD_W  = 24;  // exact row * width + column
  localparam int PIX_W   = 16;
  localparam int BYTE_W  = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_POSITION      = 3'd0,
    REG_Y_POSITION      = 3'd1,
    REG_IMAGE_WIDTH     = 3'd2,
    REG_IMAGE_HEIGHT    = 3'd3,
    REG_SOURCE_X_OFFSET = 3'd4,
    REG_SOURCE_Y_OFFSET = 3'd5,
    REG_DISPLAY_WIDTH   = 3'd6,
    REG_DISPLAY_HEIGHT  = 3'd7
  } cfg_reg_t;

  // Clipped window of one axis, in source coordinates.
  typedef struct packed {
    logic                      vis;    // at least one pixel visible
    logic [SCR_W-1:0]          start;  // first visible source index
    logic [SCR_W-1:0]          stop;   // last visible source index
    logic signed [DELTA_W-1:0] delta;  // screen index minus source index
  } axis_clip_t;

endpackage

`default_nettype wire

/* src/crgb_axis_clip.sv */
`default_nettype none

module crgb_axis_clip
  import crgb_pkg::*;
#(
  parameter int FB_SIZE = FB_WIDTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic signed [POS_W-1:0]  pos,
  input  wire logic [SIZE_W-1:0]        img,
  input  wire logic [SIZE_W-1:0]        off,
  input  wire logic [SIZE_W-1:0]        disp,
  output axis_clip_t                    clip
);

  logic signed [CLIP_W-1:0] pos_s;
  logic signed [CLIP_W-1:0] off_s;
  logic signed [CLIP_W-1:0] disp_s;
  logic signed [CLIP_W-1:0] img_s;

  logic signed [CLIP_W-1:0] off1;
  logic signed [CLIP_W-1:0] disp1;
  logic [SIZE_W-1:0]        scr1;

  logic signed [CLIP_W-1:0] rest;
  logic signed [CLIP_W-1:0] disp_fit;
  logic signed [CLIP_W-1:0] room;
  logic signed [CLIP_W-1:0] len;
  logic signed [CLIP_W-1:0] stop_full;
  logic signed [CLIP_W-1:0] delta_full;

  assign pos_s  = CLIP_W'(pos);
  assign off_s  = $signed({{(CLIP_W-SIZE_W){1'b0}}, off});
  assign disp_s = $signed({{(CLIP_W-SIZE_W){1'b0}}, disp});
  assign img_s  = $signed({{(CLIP_W-SIZE_W){1'b0}}, img});

  // First stage: a negative placement moves the source offset and
  // shrinks the window, and the window then starts at screen index zero.
  always_ff @(posedge clk) begin
    if (pos[POS_W-1]) begin
      off1  <= off_s - pos_s;
      disp1 <= disp_s + pos_s;
      scr1  <= '0;
    end else begin
      off1  <= off_s;
      disp1 <= disp_s;
      scr1  <= pos[SIZE_W-1:0];
    end
  end

  // Second stage: fall back to the rest of the image when the display size
  // is not positive or exceeds it, then cut at the framebuffer edge.
  always_comb begin
    rest       = img_s - off1;
    disp_fit   = ((disp1 <= 0) || (disp1 > rest)) ? rest : disp1;
    room       = CLIP_W'(FB_SIZE) - $signed({{(CLIP_W-SIZE_W){1'b0}}, scr1});
    len        = (room < disp_fit) ? room : disp_fit;
    stop_full  = off1 + len - CLIP_W'(1);
    delta_full = $signed({{(CLIP_W-SIZE_W){1'b0}}, scr1}) - off1;
  end

  always_ff @(posedge clk) begin
    clip.vis   <= (len > 0);
    clip.start <= off1[SCR_W-1:0];
    clip.stop  <= stop_full[SCR_W-1:0];
    clip.delta <= delta_full[DELTA_W-1:0];
  end

endmodule

`default_nettype wire

/* src/clipped_rgb24_to_rgb565_blit.sv */
`default_nettype none

// Clipped blit of a 24-bit pixel stream into an RGB565 framebuffer. Source
// pixels are taken in raster order, one item per clock while in_ready is
// high, and the block counts column and row itself; every pixel that falls
// inside the clipped window gives one result with its framebuffer word
// address, packed 5-6-5 word and a flag on the last visible pixel of the
// frame. Pixels off screen give no result. An accepted item is held in the
// input register and then loaded into the result register, where its result
// becomes valid; a stalled result holds the input register and with it
// in_ready. The address is one constant multiply by the framebuffer width
// plus one add. The window is worked out from the registers by a two-stage
// clip unit, so in_ready stays low after reset and after each configuration
// write while it refreshes.

module clipped_rgb24_to_rgb565_blit
  import crgb_pkg::*;
#(
  parameter int FB_WIDTH  = FB_WIDTH_DEF,
  parameter int FB_HEIGHT = FB_HEIGHT_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [BYTE_W-1:0]     first_byte,
  input  wire logic [BYTE_W-1:0]     second_byte,
  input  wire logic [BYTE_W-1:0]     third_byte,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [ADDR_W-1:0]          fb_address,
  output logic [PIX_W-1:0]           pixel_value,
  output logic                       window_last
);

  // Configuration registers.
  logic signed [POS_W-1:0] x_position;
  logic signed [POS_W-1:0] y_position;
  logic [SIZE_W-1:0]       image_width;
  logic [SIZE_W-1:0]       image_height;
  logic [SIZE_W-1:0]       source_x_offset;
  logic [SIZE_W-1:0]       source_y_offset;
  logic [SIZE_W-1:0]       display_width;
  logic [SIZE_W-1:0]       display_height;
  logic                    settle;

  // Source position counters.
  logic [SIZE_W-1:0] source_column;
  logic [SIZE_W-1:0] source_row;
  logic [SIZE_W-1:0] source_column_next;
  logic [SIZE_W-1:0] source_row_next;

  // Input register.
  logic              s1_valid;
  logic [PIX_W-1:0]  s1_pixel;
  logic [SIZE_W-1:0] s1_col;
  logic [SIZE_W-1:0] s1_row;

  axis_clip_t clip_x;
  axis_clip_t clip_y;

  logic                      in_fire;
  logic                      s1_hit;
  logic                      s1_last;
  logic                      out_free;
  logic                      out_load;
  logic signed [DELTA_W-1:0] x_scr_full;
  logic signed [DELTA_W-1:0] y_scr_full;
  logic [PROD_W-1:0]         addr_full;

  // Register writes; the clip unit must catch up afterwards and right after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      x_position      <= '0;
      y_position      <= '0;
      image_width     <= '0;
      image_height    <= '0;
      source_x_offset <= '0;
      source_y_offset <= '0;
      display_width   <= '0;
      display_height  <= '0;
      settle          <= 1'b1;
    end else begin
      settle <= cfg_write;
      if (cfg_write) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_X_POSITION:      x_position      <= $signed(cfg_data[POS_W-1:0]);
          REG_Y_POSITION:      y_position      <= $signed(cfg_data[POS_W-1:0]);
          REG_IMAGE_WIDTH:     image_width     <= cfg_data[SIZE_W-1:0];
          REG_IMAGE_HEIGHT:    image_height    <= cfg_data[SIZE_W-1:0];
          REG_SOURCE_X_OFFSET: source_x_offset <= cfg_data[SIZE_W-1:0];
          REG_SOURCE_Y_OFFSET: source_y_offset <= cfg_data[SIZE_W-1:0];
          REG_DISPLAY_WIDTH:   display_width   <= cfg_data[SIZE_W-1:0];
          REG_DISPLAY_HEIGHT:  display_height  <= cfg_data[SIZE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  crgb_axis_clip #(.FB_SIZE(FB_WIDTH)) u_clip_x (
    .clk  (clk),
    .pos  (x_position),
    .img  (image_width),
    .off  (source_x_offset),
    .disp (display_width),
    .clip (clip_x)
  );

  crgb_axis_clip #(.FB_SIZE(FB_HEIGHT)) u_clip_y (
    .clk  (clk),
    .pos  (y_position),
    .img  (image_height),
    .off  (source_y_offset),
    .disp (display_height),
    .clip (clip_y)
  );

  // Window test and address for the item in the input register.
  always_comb begin
    s1_hit = clip_x.vis && clip_y.vis &&
             ({1'b0, s1_col} >= clip_x.start) && ({1'b0, s1_col} <= clip_x.stop) &&
             ({1'b0, s1_row} >= clip_y.start) && ({1'b0, s1_row} <= clip_y.stop);
    s1_last    = ({1'b0, s1_col} == clip_x.stop) && ({1'b0, s1_row} == clip_y.stop);
    x_scr_full = $signed({{(DELTA_W-SIZE_W){1'b0}}, s1_col}) + clip_x.delta;
    y_scr_full = $signed({{(DELTA_W-SIZE_W){1'b0}}, s1_row}) + clip_y.delta;
    addr_full  = PROD_W'(y_scr_full[SCR_W-1:0]) * PROD_W'(FB_WIDTH) +
                 PROD_W'(x_scr_full[SCR_W-1:0]);
  end

  // Handshake: the input register drains when its item gives no result
  // or when the result register can take it.
  assign out_free = !out_valid || out_ready;
  assign out_load = s1_valid && s1_hit && out_free;
  assign in_ready = !settle && (!s1_valid || !s1_hit || out_free);
  assign in_fire  = in_valid && in_ready;

  // Raster counters with wrap at the image edges.
  always_comb begin
    source_column_next = source_column;
    source_row_next    = source_row;
    if ({1'b0, source_column} + 12'd1 >= {1'b0, image_width}) begin
      source_column_next = '0;
      if ({1'b0, source_row} + 12'd1 >= {1'b0, image_height}) begin
        source_row_next = '0;
      end else begin
        source_row_next = source_row + SIZE_W'(1);
      end
    end else begin
      source_column_next = source_column + SIZE_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      source_column <= '0;
      source_row    <= '0;
      s1_valid      <= 1'b0;
    end else begin
      if (in_fire) begin
        source_column <= source_column_next;
        source_row    <= source_row_next;
      end
      if (in_fire) begin
        s1_valid <= 1'b1;
      end else if (!s1_hit || out_free) begin
        s1_valid <= 1'b0;
      end
    end
  end

  // Input payload: the 5-6-5 packing is pure wiring.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pixel <= {third_byte[7:3], second_byte[7:2], first_byte[7:3]};
      s1_col   <= source_column;
      s1_row   <= source_row;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      fb_address  <= addr_full[ADDR_W-1:0];
      pixel_value <= s1_pixel;
      window_last <= s1_last;
    end
  end

`ifndef SYNTHESIS
  // No item is taken while the clip unit refreshes after a write.
  assert property (@(posedge clk) disable iff (rst) cfg_write |=> !in_ready)
    else $error("item accepted right after a configuration write");

  // A result is only loaded while both clipped axes have a visible pixel.
  assert property (@(posedge clk) disable iff (rst)
    out_load |-> (clip_x.vis && clip_y.vis))
    else $error("result loaded with an empty window");

  // A new result always comes from a hit in the input register.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_valid && s1_hit))
    else $error("result appeared without a visible source pixel");

  // The column wraps at the end of an image line.
  assert property (@(posedge clk) disable iff (rst)
    (in_fire && ({1'b0, source_column} + 12'd1 >= {1'b0, image_width}))
      |=> (source_column == '0))
    else $error("source column did not wrap");
`endif

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import crgb_pkg::*;

  // One expected framebuffer write.
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  pix;
    logic              last;
  } fb_write_t;

  typedef enum logic {ROW_CFG, ROW_PIXEL} row_kind_t;
  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_TYPED} check_t;
  typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  // One row of the directed table: a register write or a pixel item.
  typedef struct {
    row_kind_t             kind;
    cfg_reg_t              regsel;
    logic [CFG_DATA_W-1:0] data;
    logic [BYTE_W-1:0]     b0, b1, b2;
    check_t                chk;
    fb_write_t             want;
  } step_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [BYTE_W-1:0]     first_byte = '0;
  logic [BYTE_W-1:0]     second_byte = '0;
  logic [BYTE_W-1:0]     third_byte = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [ADDR_W-1:0]     fb_address;
  logic [PIX_W-1:0]      pixel_value;
  logic                  window_last;

  // Register mirror and raster counters of the predictor.
  int x_pos = 0, y_pos = 0;
  int img_w = 0, img_h = 0;
  int off_x = 0, off_y = 0;
  int disp_w = 0, disp_h = 0;
  int src_col = 0, src_row = 0;

  fb_write_t  expected_writes [$];
  fb_write_t  front_write;
  fb_write_t  seen_write;
  step_row_t  directed_rows [$];
  int         mismatches = 0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;

  clipped_rgb24_to_rgb565_blit dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .first_byte  (first_byte),
    .second_byte (second_byte),
    .third_byte  (third_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .fb_address  (fb_address),
    .pixel_value (pixel_value),
    .window_last (window_last)
  );

  always #5 clk = ~clk;

  // Hard stop in case the block hangs.
  initial begin
    #5_000_000;
    $display("FAIL clipped_rgb24_to_rgb565_blit");
    $finish;
  end

  // Clip one axis of the window: screen start, source start and visible length.
  function automatic void clip_span(input int pos, input int img, input int off,
                                    input int disp, input int fb, output int scr,
                                    output int src, output int len);
    int rest;
    if (pos < 0) begin
      off -= pos;
      disp += pos;
      pos = 0;
    end
    rest = img - off;
    if (disp <= 0 || disp > rest) disp = rest;
    scr = pos;
    src = off;
    len = (fb - pos < disp) ? fb - pos : disp;
  endfunction

  // Predicts the write for one source pixel and advances the raster counters.
  function automatic bit blit_predict(input logic [BYTE_W-1:0] b0, input logic [BYTE_W-1:0] b1,
                                      input logic [BYTE_W-1:0] b2, output fb_write_t res);
    int     sx, ix, vw, sy, iy, vh;
    bit     hit;
    longint flat;
    clip_span(x_pos, img_w, off_x, disp_w, FB_WIDTH_DEF, sx, ix, vw);
    clip_span(y_pos, img_h, off_y, disp_h, FB_HEIGHT_DEF, sy, iy, vh);
    hit = vw > 0 && vh > 0 && src_col >= ix && src_col < ix + vw &&
          src_row >= iy && src_row < iy + vh;
    res = '0;
    if (hit) begin
      flat = longint'(sy + src_row - iy) * FB_WIDTH_DEF + longint'(sx + src_col - ix);
      res.addr = flat[ADDR_W-1:0];
      res.pix  = {b2[7:3], b1[7:2], b0[7:3]};
      res.last = (src_col == ix + vw - 1) && (src_row == iy + vh - 1);
    end
    // The column wraps at the image width and the row at the image height.
    if (src_col + 1 >= img_w) begin
      src_col = 0;
      src_row = (src_row + 1 >= img_h) ? 0 : src_row + 1;
    end else begin
      src_col++;
    end
    return hit;
  endfunction

  function automatic step_row_t cfg_row(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    step_row_t r;
    r = '{ROW_CFG, idx, data, 8'h00, 8'h00, 8'h00, CHK_NONE, '0};
    return r;
  endfunction

  function automatic step_row_t pix_row(input logic [BYTE_W-1:0] b0, input logic [BYTE_W-1:0] b1,
                                        input logic [BYTE_W-1:0] b2, input check_t chk,
                                        input logic [ADDR_W-1:0] addr,
                                        input logic [PIX_W-1:0] pix, input logic last);
    step_row_t r;
    r = '{ROW_PIXEL, REG_X_POSITION, '0, b0, b1, b2, chk, '0};
    r.want.addr = addr;
    r.want.pix  = pix;
    r.want.last = last;
    return r;
  endfunction

  // Placement that lies near one of the screen edges most of the time.
  function automatic int near_edge(input int extent);
    case ($urandom_range(3))
      0: return int'($urandom_range(2 * extent + 4)) - extent - 2;
      1: return FB_WIDTH_DEF - extent - 2 + int'($urandom_range(extent + 4));
      2: return int'($urandom_range(40));
      default: return int'($urandom_range(4095)) - 2048;
    endcase
  endfunction

  function automatic int pick_extreme(input int lo, input int hi);
    case ($urandom_range(3))
      0: return lo;
      1: return hi;
      2: return lo + int'($urandom_range(hi - lo));
      default: return lo + 1;
    endcase
  endfunction

  function automatic void set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_SENDER: begin
        send_idle_pct = 87;
        recv_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct = 0;
        recv_stall_pct = 87;
      end
      IDLE_BOTH: begin
        send_idle_pct = 6;
        recv_stall_pct = 6;
      end
      default: begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
    endcase
  endfunction

  // Writes one register at the next edge and updates the mirror; the caller
  // lowers cfg_write after the last write of a batch.
  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_X_POSITION:      x_pos = int'($signed(data));
      REG_Y_POSITION:      y_pos = int'($signed(data));
      REG_IMAGE_WIDTH:     img_w = int'(data[SIZE_W-1:0]);
      REG_IMAGE_HEIGHT:    img_h = int'(data[SIZE_W-1:0]);
      REG_SOURCE_X_OFFSET: off_x = int'(data[SIZE_W-1:0]);
      REG_SOURCE_Y_OFFSET: off_y = int'(data[SIZE_W-1:0]);
      REG_DISPLAY_WIDTH:   disp_w = int'(data[SIZE_W-1:0]);
      default:             disp_h = int'(data[SIZE_W-1:0]);
    endcase
  endtask

  // Stops sending and waits until every expected write has come out, plus a
  // margin for a pixel that is still in flight but gives no write.
  task automatic drain_stream();
    in_valid <= 1'b0;
    while (expected_writes.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Offers one pixel item and records the write it should cause.
  task automatic send_pixel(input logic [BYTE_W-1:0] b0, input logic [BYTE_W-1:0] b1,
                            input logic [BYTE_W-1:0] b2, input check_t chk,
                            input fb_write_t typed);
    fb_write_t res;
    bit        hit;
    while (int'($urandom_range(99)) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    first_byte  <= b0;
    second_byte <= b1;
    third_byte  <= b2;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    hit = blit_predict(b0, b1, b2, res);
    case (chk)
      CHK_MODEL: if (hit) expected_writes.push_back(res);
      CHK_TYPED: expected_writes.push_back(typed);
      default: ;
    endcase
  endtask

  // Result side: check each accepted write, then decide the next stall.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      seen_write.addr = fb_address;
      seen_write.pix  = pixel_value;
      seen_write.last = window_last;
      if (expected_writes.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected write: addr=%0d pix=%h last=%b",
                   fb_address, pixel_value, window_last);
        mismatches++;
      end else begin
        front_write = expected_writes.pop_front();
        if (seen_write.addr !== front_write.addr || seen_write.pix !== front_write.pix ||
            seen_write.last !== front_write.last) begin
          if (mismatches < 10)
            $display("write mismatch: expected addr=%0d pix=%h last=%b, got addr=%0d pix=%h last=%b",
                     front_write.addr, front_write.pix, front_write.last,
                     seen_write.addr, seen_write.pix, seen_write.last);
          mismatches++;
        end
      end
    end
    out_ready <= (int'($urandom_range(99)) >= recv_stall_pct);
  end

  initial begin
    logic [CFG_DATA_W-1:0] vals [0:7];
    int        iw, ih, xp, yp, n, kind, phase, random_items;
    fb_write_t no_write;

    no_write = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // With every register at zero the window is empty.
    directed_rows.push_back(pix_row(8'hff, 8'hff, 8'hff, CHK_NONE, 0, 16'h0000, 1'b0));
    directed_rows.push_back(pix_row(8'h00, 8'h00, 8'h00, CHK_NONE, 0, 16'h0000, 1'b0));
    // A 3 by 2 image in the top left corner: byte extremes and each color lane.
    directed_rows.push_back(cfg_row(REG_IMAGE_WIDTH, 12'd3));
    directed_rows.push_back(cfg_row(REG_IMAGE_HEIGHT, 12'd2));
    directed_rows.push_back(pix_row(8'hff, 8'hff, 8'hff, CHK_TYPED, 0, 16'hffff, 1'b0));
    directed_rows.push_back(pix_row(8'h00, 8'h00, 8'h00, CHK_TYPED, 1, 16'h0000, 1'b0));
    directed_rows.push_back(pix_row(8'hf8, 8'h00, 8'h00, CHK_TYPED, 2, 16'h001f, 1'b0));
    directed_rows.push_back(pix_row(8'h00, 8'hfc, 8'h00, CHK_TYPED, 1024, 16'h07e0, 1'b0));
    directed_rows.push_back(pix_row(8'h00, 8'h00, 8'hf8, CHK_TYPED, 1025, 16'hf800, 1'b0));
    directed_rows.push_back(pix_row(8'h07, 8'h03, 8'h07, CHK_TYPED, 1026, 16'h0000, 1'b1));
    // Negative column placement and the bottom screen edge.
    directed_rows.push_back(cfg_row(REG_X_POSITION, 12'hfff));
    directed_rows.push_back(cfg_row(REG_Y_POSITION, 12'd1023));
    directed_rows.push_back(pix_row(8'h12, 8'h34, 8'h56, CHK_MODEL, 0, 16'h0, 1'b0));
    directed_rows.push_back(pix_row(8'h80, 8'h80, 8'h80, CHK_MODEL, 0, 16'h0, 1'b0));
    directed_rows.push_back(pix_row(8'h7f, 8'h7f, 8'h7f, CHK_MODEL, 0, 16'h0, 1'b0));
    directed_rows.push_back(pix_row(8'haa, 8'h55, 8'haa, CHK_MODEL, 0, 16'h0, 1'b0));
    directed_rows.push_back(pix_row(8'h55, 8'haa, 8'h55, CHK_MODEL, 0, 16'h0, 1'b0));
    directed_rows.push_back(pix_row(8'h01, 8'h02, 8'h04, CHK_MODEL, 0, 16'h0, 1'b0));
    // Oversized display width and the largest placement: fully off screen.
    directed_rows.push_back(cfg_row(REG_DISPLAY_WIDTH, 12'd2047));
    directed_rows.push_back(cfg_row(REG_X_POSITION, 12'h7ff));
    directed_rows.push_back(pix_row(8'hff, 8'h00, 8'hff, CHK_MODEL, 0, 16'h0, 1'b0));
    directed_rows.push_back(pix_row(8'h00, 8'hff, 8'h00, CHK_MODEL, 0, 16'h0, 1'b0));
    // Most negative placement pushes the offset past the image.
    directed_rows.push_back(cfg_row(REG_X_POSITION, 12'h800));
    directed_rows.push_back(pix_row(8'hff, 8'hff, 8'hff, CHK_NONE, 0, 16'h0000, 1'b0));
    directed_rows.push_back(pix_row(8'h00, 8'h00, 8'h00, CHK_NONE, 0, 16'h0000, 1'b0));

    set_idling(IDLE_NONE);
    for (int i = 0; i < directed_rows.size(); i++) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        if (i == 0 || directed_rows[i-1].kind != ROW_CFG) drain_stream();
        write_reg(directed_rows[i].regsel, directed_rows[i].data);
        if (i + 1 == directed_rows.size() || directed_rows[i+1].kind != ROW_CFG)
          cfg_write <= 1'b0;
      end else begin
        send_pixel(directed_rows[i].b0, directed_rows[i].b1, directed_rows[i].b2,
                   directed_rows[i].chk, directed_rows[i].want);
      end
    end

    // Random phases: each picks a window, an idling mode and a run of pixels.
    phase = 0;
    random_items = 0;
    while (random_items < 2000) begin
      kind = $urandom_range(9);
      if (kind < 7) begin
        // Small frames placed around the screen edges.
        iw = 1 + $urandom_range(11);
        ih = 1 + $urandom_range(9);
        xp = near_edge(iw);
        yp = near_edge(ih);
        vals[REG_SOURCE_X_OFFSET] = 12'($urandom_range(iw));
        vals[REG_SOURCE_Y_OFFSET] = 12'($urandom_range(ih));
        vals[REG_DISPLAY_WIDTH]   = 12'($urandom_range(iw + 2));
        vals[REG_DISPLAY_HEIGHT]  = 12'($urandom_range(ih + 2));
      end else if (kind < 9) begin
        iw = pick_extreme(0, 2047);
        ih = pick_extreme(0, 2047);
        xp = pick_extreme(-2048, 2047);
        yp = pick_extreme(-2048, 2047);
        vals[REG_SOURCE_X_OFFSET] = 12'(pick_extreme(0, 2047));
        vals[REG_SOURCE_Y_OFFSET] = 12'(pick_extreme(0, 2047));
        vals[REG_DISPLAY_WIDTH]   = 12'(pick_extreme(0, 2047));
        vals[REG_DISPLAY_HEIGHT]  = 12'(pick_extreme(0, 2047));
      end else begin
        iw = $urandom_range(2047);
        ih = $urandom_range(2047);
        xp = int'($urandom_range(4095)) - 2048;
        yp = int'($urandom_range(4095)) - 2048;
        vals[REG_SOURCE_X_OFFSET] = 12'($urandom_range(2047));
        vals[REG_SOURCE_Y_OFFSET] = 12'($urandom_range(2047));
        vals[REG_DISPLAY_WIDTH]   = 12'($urandom_range(2047));
        vals[REG_DISPLAY_HEIGHT]  = 12'($urandom_range(2047));
      end
      vals[REG_X_POSITION]   = xp[11:0];
      vals[REG_Y_POSITION]   = yp[11:0];
      vals[REG_IMAGE_WIDTH]  = {1'b0, iw[10:0]};
      vals[REG_IMAGE_HEIGHT] = {1'b0, ih[10:0]};
      // The unused top data bit of the unsigned registers must be ignored.
      for (int k = 2; k < 8; k++)
        if ($urandom_range(7) == 0) vals[k][11] = 1'b1;

      drain_stream();
      for (int k = 0; k < 8; k++)
        write_reg(cfg_reg_t'(k), vals[k]);
      cfg_write <= 1'b0;

      set_idling(idle_mode_t'(phase % 4));
      n = 40 + $urandom_range(160);
      for (int i = 0; i < n; i++) begin
        // Now and then the source holds off until all writes are out.
        if (phase % 3 == 1 && i == n / 2) drain_stream();
        send_pixel(8'($urandom_range(255)), 8'($urandom_range(255)),
                   8'($urandom_range(255)), CHK_MODEL, no_write);
      end
      random_items += n;
      phase++;
    end

    drain_stream();
    repeat (20) @(posedge clk);
    if (mismatches == 0)
      $display("PASS clipped_rgb24_to_rgb565_blit");
    else
      $display("FAIL clipped_rgb24_to_rgb565_blit");
    $finish;
  end

endmodule

/* sim.f */
src/crgb_pkg.sv
src/crgb_axis_clip.sv
src/clipped_rgb24_to_rgb565_blit.sv
tb/tb_top.sv
